/* hw/rtl/cpba_pkg.sv */
// ----------------------------------------------------------------------------
// cpba_pkg
// Shared types, codes and defaults of the contiguous page bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package cpba_pkg;
  localparam int NumPagesDef = 4096;
  localparam int MaxOrderDef = 10;
  localparam int WordW       = 64;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_MARK  = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_ORDER   = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  typedef logic [WordW-1:0] word_t;
endpackage
`default_nettype wire

/* hw/rtl/contiguous_page_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator
// Used/free bitmap of a page area in a 64-bit word memory; first-fit run
// allocation, run free and single page mark.
// ----------------------------------------------------------------------------
//  channel | ports                                 | dir
//  request | in_valid in_ready in_opcode/order/page_index | in
//  result  | out_valid out_ready out_status out_first_page | out
//
// After reset a clearing pass writes every word to zero; no request is
// accepted meanwhile. Allocate scans the map word by word (read, then
// check), then writes the run word by word (read, then modify). Free and
// mark read, then modify, each touched word. One request is in work at
// a time; a result waiting in the output register holds off the next request.
`default_nettype none
module contiguous_page_bitmap_allocator
  import cpba_pkg::*;
#(
  parameter int NUM_PAGES   = NumPagesDef,
  parameter int ORDER_LIMIT = MaxOrderDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [3:0]  in_order,
  input  wire logic [11:0] in_page_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [11:0]      out_first_page
);
  localparam int Words = (NUM_PAGES + WordW - 1) / WordW;
  localparam int AW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int PW    = $clog2(NUM_PAGES) + 1;
  localparam int BW    = $clog2(WordW);
  localparam int CW    = ((PW > 16) ? PW : 16) + 1;

  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_SRD = 3'd2,
                         S_SCHK = 3'd3, S_WRD = 3'd4, S_WMOD = 3'd5,
                         S_DONE = 3'd6;

  word_t mem [Words];
  word_t rd_q;
  logic  we;
  logic [AW-1:0] waddr, raddr;
  word_t wdata;

  logic [2:0]     state_r, state_nxt;
  logic [AW-1:0]  addr_r, addr_nxt;
  logic [CW-1:0]  run_r, run_nxt;    // free run length so far
  logic [CW-1:0]  start_r, start_nxt; // run start / fill cursor
  logic [CW-1:0]  left_r, left_nxt;   // pages left to fill
  logic [CW-1:0]  len_r, len_nxt;
  logic           setv_r, setv_nxt;
  logic [1:0]     st_r, st_nxt;
  logic [11:0]    fp_r, fp_nxt;
  logic           ov_r, ov_nxt;

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  assign in_ready       = (state_r == S_IDLE) && !ov_r;
  assign out_valid      = ov_r;
  assign out_status     = st_r;
  assign out_first_page = fp_r;

  // Scan one word: free run ending at each bit, lowest fitting end wins
  logic [CW-1:0] srun;
  logic [CW-1:0] sfound;
  logic          shit;
  logic [CW-1:0] base;
  logic [CW-1:0] brun;
  logic [BW-1:0] lastu;
  logic          seen;
  always_comb begin
    base   = CW'(addr_r) << BW;
    srun   = run_r;
    shit   = 1'b0;
    sfound = '0;
    seen   = 1'b0;
    lastu  = '0;
    brun   = '0;
    for (int b = 0; b < WordW; b++) begin
      if (rd_q[b]) begin
        seen  = 1'b1;
        lastu = BW'(b);
      end
      brun = seen ? CW'(BW'(b) - lastu) : run_r + CW'(b + 1);
      if (!shit && ((base + CW'(b)) < CW'(NUM_PAGES))) begin
        srun = brun;
        if (brun >= len_r) begin
          shit   = 1'b1;
          sfound = base + CW'(b) + CW'(1) - len_r;
        end
      end
    end
  end

  // Word fill mask for the current cursor
  word_t fmask;
  logic [CW-1:0] wend, nfill;
  always_comb begin
    wend  = (CW'(start_r >> BW) + 1'b1) << BW;
    nfill = ((wend - start_r) < left_r) ? (wend - start_r) : left_r;
    fmask = '0;
    for (int b = 0; b < WordW; b++)
      if ((CW'(b) >= CW'(start_r[BW-1:0])) &&
          (CW'(b) < CW'(start_r[BW-1:0]) + nfill)) fmask[b] = 1'b1;
  end

  logic [CW-1:0] in_len;
  assign in_len = CW'(1) << in_order;

  // Sequencer
  always_comb begin
    state_nxt = state_r; addr_nxt = addr_r; run_nxt = run_r;
    start_nxt = start_r; left_nxt = left_r; len_nxt = len_r;
    setv_nxt = setv_r; st_nxt = st_r; fp_nxt = fp_r; ov_nxt = ov_r;
    we = 1'b0; waddr = addr_r; wdata = '0; raddr = addr_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_CLR: begin
        we = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == AW'(Words - 1)) begin
          addr_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          st_nxt = ST_OK; fp_nxt = '0; len_nxt = in_len;
          run_nxt = '0; addr_nxt = '0;
          case (in_opcode)
            OP_ALLOC: begin
              if (in_order > 4'(ORDER_LIMIT)) begin
                st_nxt = ST_ORDER; ov_nxt = 1'b1;
              end else state_nxt = S_SRD;
            end
            OP_FREE: begin
              if (CW'(in_page_index) + in_len > CW'(NUM_PAGES)) begin
                st_nxt = ST_RANGE; ov_nxt = 1'b1;
              end else begin
                start_nxt = CW'(in_page_index); left_nxt = in_len;
                setv_nxt = 1'b0; state_nxt = S_WRD;
              end
            end
            OP_MARK: begin
              if (CW'(in_page_index) >= CW'(NUM_PAGES)) begin
                st_nxt = ST_RANGE; ov_nxt = 1'b1;
              end else begin
                start_nxt = CW'(in_page_index); left_nxt = CW'(1);
                setv_nxt = 1'b1; state_nxt = S_WRD;
              end
            end
            default: begin
              st_nxt = ST_RANGE; ov_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SRD: state_nxt = S_SCHK;
      S_SCHK: begin
        run_nxt = srun;
        if (shit) begin
          start_nxt = sfound; left_nxt = len_r; setv_nxt = 1'b1;
          fp_nxt = 12'(sfound); state_nxt = S_WRD;
        end else if (addr_r == AW'(Words - 1)) begin
          st_nxt = ST_NOSPACE; state_nxt = S_DONE;
        end else begin
          addr_nxt = addr_r + 1'b1; state_nxt = S_SRD;
        end
      end
      S_WRD: begin
        raddr = AW'(start_r >> BW);
        state_nxt = S_WMOD;
      end
      S_WMOD: begin
        we = 1'b1;
        waddr = AW'(start_r >> BW);
        wdata = setv_r ? (rd_q | fmask) : (rd_q & ~fmask);
        start_nxt = start_r + nfill;
        left_nxt = left_r - nfill;
        state_nxt = (left_r == nfill) ? S_DONE : S_WRD;
      end
      S_DONE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; addr_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; addr_r <= addr_nxt; ov_r <= ov_nxt;
    end
    run_r <= run_nxt; start_r <= start_nxt; left_r <= left_nxt;
    len_r <= len_nxt; setv_r <= setv_nxt; st_r <= st_nxt; fp_r <= fp_nxt;
  end

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_first_page == '0)
    else $error("first_page nonzero on error");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("request taken while busy");
  a_write_only_mod: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_CLR || state_r == S_WMOD))
    else $error("stray memory write");
  a_wmod_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WMOD) |-> $past(state_r) == S_WRD)
    else $error("write without read");
endmodule
`default_nettype wire

/* sim/cpba_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpba_checker
// Watches the request and result channels of the page bitmap allocator,
// keeps its own copy of the used/free map, predicts each result and compares
// it field by field with what the block returns.
// ----------------------------------------------------------------------------
module cpba_checker
  import cpba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [3:0]  in_order,
  input  wire logic [11:0] in_page_index,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  out_status,
  input  wire logic [11:0] out_first_page,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] first_page;
  } alloc_result_t;

  logic [NumPagesDef-1:0] page_map;
  alloc_result_t          result_q[$];

  // Lowest start of a free run of len pages, or NumPagesDef if none fits
  function automatic int find_free_run(int len);
    int run;
    run = 0;
    for (int i = 0; i < NumPagesDef; i++) begin
      if (page_map[i]) begin
        run = 0;
      end else begin
        run++;
        if (run >= len) return i + 1 - len;
      end
    end
    return NumPagesDef;
  endfunction

  // Apply one request to the map and work out its result
  function automatic alloc_result_t apply_request(logic [1:0] op, logic [3:0] ord,
                                                  logic [11:0] pg);
    alloc_result_t r;
    int            len;
    int            idx;
    r   = '{status: ST_OK, first_page: '0};
    len = 1 << ord;
    case (op)
      OP_ALLOC: begin
        if (ord > MaxOrderDef) begin
          r.status = ST_ORDER;
        end else begin
          idx = find_free_run(len);
          if (idx >= NumPagesDef) begin
            r.status = ST_NOSPACE;
          end else begin
            for (int i = 0; i < len; i++) page_map[idx + i] = 1'b1;
            r.first_page = idx[11:0];
          end
        end
      end
      OP_FREE: begin
        // end check is inclusive: a run may end exactly at the area end
        if (int'(pg) + len > NumPagesDef) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = 0; i < len; i++) page_map[int'(pg) + i] = 1'b0;
        end
      end
      OP_MARK: begin
        page_map[pg] = 1'b1;
      end
      default: r.status = ST_RANGE;
    endcase
    return r;
  endfunction

  assign pending = result_q.size();

  // Compare results with the oldest prediction, then predict new requests
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (!rst_n) begin
      page_map   = '0;
      fail_count = 0;
      result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t unexpected result status %0d first_page %0d",
                   $time, out_status, out_first_page);
          fail_count++;
        end else begin
          exp_r = result_q.pop_front();
          if (out_status !== exp_r.status) begin
            $display("%0t status mismatch: expected %0d actual %0d",
                     $time, exp_r.status, out_status);
            fail_count++;
          end
          if (out_first_page !== exp_r.first_page) begin
            $display("%0t first_page mismatch: expected %0d actual %0d",
                     $time, exp_r.first_page, out_first_page);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        result_q.push_back(apply_request(in_opcode, in_order, in_page_index));
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives requests into the page bitmap allocator under changing idle
// patterns and a long receiver stall, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import cpba_pkg::*;

  localparam int PhaseItems = 550;
  localparam int WatchLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [3:0]  in_order;
  logic [11:0] in_page_index;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [11:0] out_first_page;
  int          fail_count;
  int          pending;
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          rx_hold;
  int          idle_cycles;

  contiguous_page_bitmap_allocator u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_order       (in_order),
    .in_page_index  (in_page_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_first_page (out_first_page)
  );

  cpba_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_order       (in_order),
    .in_page_index  (in_page_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_first_page (out_first_page),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver: stall at random, or hold off completely during a long stall
  always @(negedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offer one request, with a random gap first, and hold it until accepted
  task automatic send_request(logic [1:0] op, logic [3:0] ord, logic [11:0] pg);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_order      <= ord;
    in_page_index <= pg;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Mostly well-formed traffic, small runs, with some bad requests mixed in
  task automatic send_random_request();
    int          r;
    logic [1:0]  op;
    logic [3:0]  ord;
    logic [11:0] pg;
    r   = $urandom_range(99);
    pg  = 12'($urandom_range(4095));
    ord = ($urandom_range(99) < 85) ? 4'($urandom_range(4)) : 4'($urandom_range(15));
    if (r < 40) begin
      op = OP_ALLOC;
    end else if (r < 70) begin
      op = OP_FREE;
      if ($urandom_range(99) < 6) begin
        ord = 4'd12;
        pg  = '0;
      end
    end else if (r < 88) begin
      op = OP_MARK;
    end else if (r < 94) begin
      op  = OP_RSVD;
      ord = 4'($urandom_range(15));
    end else begin
      op  = $urandom_range(1) ? OP_ALLOC : OP_FREE;
      ord = 4'($urandom_range(15));
    end
    send_request(op, ord, pg);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_ALLOC;
    in_order      = '0;
    in_page_index = '0;
    rx_hold       = 1'b0;
    tx_idle_pct   = 18;
    rx_idle_pct   = 86;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: fill the area, no space, full free, order and range limits
    repeat (4) send_request(OP_ALLOC, 4'd10, 12'd0);
    send_request(OP_ALLOC, 4'd0, 12'd0);
    send_request(OP_FREE, 4'd12, 12'd0);
    send_request(OP_FREE, 4'd12, 12'd1);
    send_request(OP_ALLOC, 4'd11, 12'hFFF);
    send_request(OP_ALLOC, 4'd15, 12'd0);
    send_request(OP_ALLOC, 4'd0, 12'hFFF);
    send_request(OP_MARK, 4'd0, 12'd0);
    send_request(OP_MARK, 4'd15, 12'd4095);
    send_request(OP_FREE, 4'd0, 12'd4095);
    send_request(OP_FREE, 4'd3, 12'd100);
    send_request(OP_RSVD, 4'd15, 12'hFFF);
    send_request(OP_FREE, 4'd4, 12'd4080);
    send_request(OP_FREE, 4'd4, 12'd4081);
    send_request(OP_FREE, 4'd15, 12'd0);
    send_request(OP_ALLOC, 4'd0, 12'd0);
    send_request(OP_ALLOC, 4'd1, 12'd0);

    // Sender pauses here until every result is back
    drain_results();
    repeat (PhaseItems) send_random_request();
    drain_results();

    tx_idle_pct = 86;
    rx_idle_pct = 18;
    repeat (PhaseItems) send_random_request();
    drain_results();

    // No idling; start with a long receiver stall so the block backs up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    repeat (PhaseItems) send_random_request();
    drain_results();

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/cpba_pkg.sv
hw/rtl/contiguous_page_bitmap_allocator.sv
sim/cpba_checker.sv
sim/tb_top.sv
